// ----- rtl/core/ghls_pkg.sv -----
// Shared types, constants and defaults for the grid histogram lane search.
// Used by every module of the block; depends on nothing.
package ghls_pkg;

    localparam int IMAGE_WIDTH_DEF  = 640;
    localparam int IMAGE_HEIGHT_DEF = 480;
    localparam int GRID_COLS_DEF    = 32;
    localparam int GRID_ROWS_DEF    = 16;

    localparam int MAX_RESULTS = 8;
    localparam int SPLIT_COUNT = 6;
    localparam int MIN_CENTERS = 3;
    localparam int HW_W        = 5;
    localparam int HW_RESET    = 5;
    localparam int X_W         = 10;
    localparam int Y_W         = 9;
    localparam int CNT_W       = 16;
    localparam int ROW_IW      = 6;
    localparam int RCP_SH      = 23;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ADD_MUL,
        S_ADD_RD,
        S_ADD_WR,
        S_ROW,
        S_SCAN,
        S_ROW_END,
        S_CLEAR
    } t_srch_state;

    typedef enum logic [1:0] {
        P_IDLE,
        P_RD,
        P_DATA,
        P_OUT
    } t_path_state;

    typedef struct packed {
        logic              we;
        logic [ROW_IW-1:0] addr;
        logic [X_W-1:0]    x;
    } t_ctr_wr;

    typedef struct packed {
        logic              valid;
        logic [ROW_IW-1:0] count;
        logic [ROW_IW-1:0] first_row;
    } t_run_done;

endpackage

// ----- rtl/core/ghls_cnt_ram.sv -----
// Cell count memory: one write port, one read port with registered read data.
// Depends on ghls_pkg for the count width.
module ghls_cnt_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic [ghls_pkg::CNT_W-1:0] i_wdata,
    input  logic [AW-1:0]           i_raddr,
    output logic [ghls_pkg::CNT_W-1:0] o_rdata
);

    logic [ghls_pkg::CNT_W-1:0] r_mem [DEPTH];
    logic [ghls_pkg::CNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ghls_search.sv -----
// Point accumulation, row search and grid clearing around the cell count memory.
// Depends on ghls_pkg and ghls_cnt_ram.
module ghls_search #(
    parameter int IMAGE_WIDTH  = ghls_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = ghls_pkg::IMAGE_HEIGHT_DEF,
    parameter int GRID_COLS    = ghls_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS    = ghls_pkg::GRID_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_cmd,
    input  logic [ghls_pkg::X_W-1:0]    i_x,
    input  logic [ghls_pkg::Y_W-1:0]    i_y,
    input  logic [ghls_pkg::HW_W-1:0]   i_hw,
    output logic                        o_idle,
    output ghls_pkg::t_ctr_wr           o_ctr_wr,
    output ghls_pkg::t_run_done         o_done
);

    localparam int CELL_W = (IMAGE_WIDTH / GRID_COLS) > 0 ? (IMAGE_WIDTH / GRID_COLS) : 1;
    localparam int CELL_H = (IMAGE_HEIGHT / GRID_ROWS) > 0 ? (IMAGE_HEIGHT / GRID_ROWS) : 1;
    localparam int DEPTH  = GRID_COLS * GRID_ROWS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CLW    = $clog2(GRID_COLS);
    localparam int RW     = $clog2(GRID_ROWS);
    localparam int EW     = CLW + 6;
    localparam int RCP_W  = ghls_pkg::RCP_SH + 1;
    localparam int RCP_X  = ((1 << ghls_pkg::RCP_SH) + CELL_W - 1) / CELL_W;
    localparam int RCP_Y  = ((1 << ghls_pkg::RCP_SH) + CELL_H - 1) / CELL_H;
    localparam int PXW    = ghls_pkg::X_W + RCP_W;
    localparam int PYW    = ghls_pkg::Y_W + RCP_W;
    localparam int LW     = 13;

    ghls_pkg::t_srch_state r_state, n_state;

    logic [ghls_pkg::X_W-1:0]   r_px, n_px;
    logic [ghls_pkg::Y_W-1:0]   r_py, n_py;
    logic [ghls_pkg::X_W-1:0]   r_cq, n_cq;
    logic [ghls_pkg::Y_W-1:0]   r_rq, n_rq;
    logic [AW-1:0]              r_addr, n_addr;
    logic [AW-1:0]              r_clr, n_clr;
    logic [RW-1:0]              r_row, n_row;
    logic [RW-1:0]              r_fr, n_fr;
    logic [CLW-1:0]             r_col, n_col;
    logic [CLW-1:0]             r_c, n_c;
    logic [CLW-1:0]             r_hi, n_hi;
    logic [CLW-1:0]             r_pc, n_pc;
    logic                       r_iss, n_iss;
    logic                       r_pend, n_pend;
    logic                       r_started, n_started;
    logic [ghls_pkg::CNT_W-1:0] r_best, n_best;
    logic [ghls_pkg::ROW_IW-1:0] r_n, n_n;

    logic [PXW-1:0]             w_prod_x;
    logic [PYW-1:0]             w_prod_y;
    logic                       w_add_ok;
    logic [AW-1:0]              w_add_addr;
    logic [EW-1:0]              w_col_e;
    logic [EW-1:0]              w_hw_e;
    logic [EW-1:0]              w_lo_e;
    logic [EW-1:0]              w_hi_e;

    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [ghls_pkg::CNT_W-1:0] w_wdata;
    logic [AW-1:0]              w_raddr;
    logic [ghls_pkg::CNT_W-1:0] w_rdata;

    ghls_cnt_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_prod_x   = PXW'(r_px) * PXW'(RCP_X);
    assign w_prod_y   = PYW'(r_py) * PYW'(RCP_Y);
    assign w_add_ok   = (LW'(r_px) < LW'(IMAGE_WIDTH)) && (LW'(r_py) < LW'(IMAGE_HEIGHT))
                        && (LW'(r_cq) < LW'(GRID_COLS)) && (LW'(r_rq) < LW'(GRID_ROWS));
    assign w_add_addr = AW'(r_rq) * AW'(GRID_COLS) + AW'(r_cq);
    assign w_col_e    = EW'(r_col);
    assign w_hw_e     = EW'(i_hw);
    assign w_lo_e     = (w_col_e >= w_hw_e) ? (w_col_e - w_hw_e) : '0;
    assign w_hi_e     = (w_col_e + w_hw_e - EW'(1) > EW'(GRID_COLS - 1)) ?
                        EW'(GRID_COLS - 1) : (w_col_e + w_hw_e - EW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ghls_pkg::S_INIT;
            r_clr     <= '0;
            r_iss     <= 1'b0;
            r_pend    <= 1'b0;
            r_started <= 1'b0;
            r_n       <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_iss     <= n_iss;
            r_pend    <= n_pend;
            r_started <= n_started;
            r_n       <= n_n;
        end
        r_px   <= n_px;
        r_py   <= n_py;
        r_cq   <= n_cq;
        r_rq   <= n_rq;
        r_addr <= n_addr;
        r_row  <= n_row;
        r_fr   <= n_fr;
        r_col  <= n_col;
        r_c    <= n_c;
        r_hi   <= n_hi;
        r_pc   <= n_pc;
        r_best <= n_best;
    end

    always_comb begin
        n_state   = r_state;
        n_px      = r_px;
        n_py      = r_py;
        n_cq      = r_cq;
        n_rq      = r_rq;
        n_addr    = r_addr;
        n_clr     = r_clr;
        n_row     = r_row;
        n_fr      = r_fr;
        n_col     = r_col;
        n_c       = r_c;
        n_hi      = r_hi;
        n_pc      = r_pc;
        n_iss     = r_iss;
        n_pend    = 1'b0;
        n_started = r_started;
        n_best    = r_best;
        n_n       = r_n;
        w_we      = 1'b0;
        w_waddr   = r_addr;
        w_wdata   = '0;
        w_raddr   = AW'(r_row) * AW'(GRID_COLS) + AW'(r_c);
        o_ctr_wr  = '0;
        o_done    = '0;
        case (r_state)
            ghls_pkg::S_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_clr   = '0;
                    n_state = ghls_pkg::S_IDLE;
                end
            end
            ghls_pkg::S_IDLE: begin
                if (i_start) begin
                    n_px = i_x;
                    n_py = i_y;
                    if (i_cmd == ghls_pkg::CMD_FINISH) begin
                        n_row     = RW'(GRID_ROWS - 1);
                        n_started = 1'b0;
                        n_n       = '0;
                        n_col     = '0;
                        n_state   = ghls_pkg::S_ROW;
                    end else begin
                        n_state = ghls_pkg::S_ADD_MUL;
                    end
                end
            end
            ghls_pkg::S_ADD_MUL: begin
                n_cq    = w_prod_x[ghls_pkg::RCP_SH +: ghls_pkg::X_W];
                n_rq    = w_prod_y[ghls_pkg::RCP_SH +: ghls_pkg::Y_W];
                n_state = ghls_pkg::S_ADD_RD;
            end
            ghls_pkg::S_ADD_RD: begin
                w_raddr = w_add_addr;
                n_addr  = w_add_addr;
                n_state = w_add_ok ? ghls_pkg::S_ADD_WR : ghls_pkg::S_IDLE;
            end
            ghls_pkg::S_ADD_WR: begin
                w_we    = (w_rdata != '1);
                w_wdata = w_rdata + ghls_pkg::CNT_W'(1);
                n_state = ghls_pkg::S_IDLE;
            end
            ghls_pkg::S_ROW: begin
                n_best = '0;
                if (r_row == '0) begin
                    n_clr   = '0;
                    n_state = ghls_pkg::S_CLEAR;
                end else if (!r_started) begin
                    n_c     = '0;
                    n_hi    = CLW'(GRID_COLS - 1);
                    n_iss   = 1'b1;
                    n_state = ghls_pkg::S_SCAN;
                end else if (i_hw == '0) begin
                    n_state = ghls_pkg::S_ROW_END;
                end else begin
                    n_c     = w_lo_e[CLW-1:0];
                    n_hi    = w_hi_e[CLW-1:0];
                    n_iss   = 1'b1;
                    n_state = ghls_pkg::S_SCAN;
                end
            end
            ghls_pkg::S_SCAN: begin
                if (r_iss) begin
                    n_pend = 1'b1;
                    n_pc   = r_c;
                    if (r_c == r_hi) begin
                        n_iss = 1'b0;
                    end else begin
                        n_c = r_c + CLW'(1);
                    end
                end
                if (r_pend && (w_rdata > r_best)) begin
                    n_best = w_rdata;
                    n_col  = r_pc;
                end
                if (!r_iss && !r_pend) begin
                    n_state = ghls_pkg::S_ROW_END;
                end
            end
            ghls_pkg::S_ROW_END: begin
                n_row   = r_row - RW'(1);
                n_state = ghls_pkg::S_ROW;
                if (r_started || (r_best != '0)) begin
                    n_started     = 1'b1;
                    o_ctr_wr.we   = 1'b1;
                    o_ctr_wr.addr = r_n;
                    o_ctr_wr.x    = ghls_pkg::X_W'(int'(r_col) * CELL_W + CELL_W / 2);
                    n_n           = r_n + ghls_pkg::ROW_IW'(1);
                    if (!r_started) begin
                        n_fr = r_row;
                    end
                end
            end
            ghls_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_clr            = '0;
                    o_done.valid     = 1'b1;
                    o_done.count     = r_n;
                    o_done.first_row = ghls_pkg::ROW_IW'(r_fr);
                    n_state          = ghls_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ghls_pkg::S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == ghls_pkg::S_IDLE);

endmodule

// ----- rtl/core/ghls_path.sv -----
// Row center memory and the sequencer that emits the thinned control set.
// Depends on ghls_pkg.
module ghls_path #(
    parameter int IMAGE_HEIGHT = ghls_pkg::IMAGE_HEIGHT_DEF,
    parameter int GRID_ROWS    = ghls_pkg::GRID_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ghls_pkg::t_ctr_wr           i_ctr_wr,
    input  ghls_pkg::t_run_done         i_done,
    input  logic                        i_ready,
    output logic                        o_idle,
    output logic                        o_valid,
    output logic [ghls_pkg::X_W-1:0]    o_path_x,
    output logic [ghls_pkg::Y_W-1:0]    o_path_y,
    output logic                        o_found,
    output logic                        o_last
);

    localparam int CELL_H = (IMAGE_HEIGHT / GRID_ROWS) > 0 ? (IMAGE_HEIGHT / GRID_ROWS) : 1;
    localparam int CD     = (GRID_ROWS > 16) ? GRID_ROWS : 16;
    localparam int CIW    = $clog2(CD);
    localparam int PW     = $clog2(ghls_pkg::MAX_RESULTS);
    localparam int IW     = ghls_pkg::ROW_IW;

    ghls_pkg::t_path_state r_state, n_state;

    logic [ghls_pkg::X_W-1:0] r_mem [CD];
    logic [ghls_pkg::X_W-1:0] r_rq;

    logic [IW-1:0]            r_n, n_n;
    logic [IW-1:0]            r_fr, n_fr;
    logic [IW-1:0]            r_j, n_j;
    logic [IW-1:0]            r_pj, n_pj;
    logic [PW-1:0]            r_pos, n_pos;
    logic [PW-1:0]            r_ppos, n_ppos;
    logic                     r_hp, n_hp;
    logic                     r_fin, n_fin;
    logic [ghls_pkg::X_W-1:0] r_px, n_px;
    logic [ghls_pkg::X_W-1:0] r_ox, n_ox;
    logic [ghls_pkg::Y_W-1:0] r_oy, n_oy;
    logic                     r_of, n_of;
    logic                     r_ol, n_ol;

    logic                     w_cur_last;
    logic                     w_emit_prev;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] cur, input logic [IW-1:0] n);
        logic [IW-1:0] last_i;
        last_i = n - IW'(1);
        if (cur == '0) begin
            return (n < IW'(ghls_pkg::SPLIT_COUNT)) ? IW'(1) : IW'(2);
        end else if (n < IW'(ghls_pkg::SPLIT_COUNT)) begin
            return last_i;
        end else if ((cur + IW'(1)) < (n >> 1)) begin
            return cur + IW'(1);
        end else begin
            return last_i;
        end
    endfunction

    function automatic logic [ghls_pkg::Y_W-1:0] f_y(input logic [IW-1:0] fr,
                                                    input logic [IW-1:0] j);
        return ghls_pkg::Y_W'((int'(fr) - int'(j)) * CELL_H + CELL_H / 2);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctr_wr.we) begin
            r_mem[i_ctr_wr.addr[CIW-1:0]] <= i_ctr_wr.x;
        end
        r_rq <= r_mem[r_j[CIW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ghls_pkg::P_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n    <= n_n;
        r_fr   <= n_fr;
        r_j    <= n_j;
        r_pj   <= n_pj;
        r_pos  <= n_pos;
        r_ppos <= n_ppos;
        r_hp   <= n_hp;
        r_fin  <= n_fin;
        r_px   <= n_px;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_of   <= n_of;
        r_ol   <= n_ol;
    end

    assign w_cur_last  = (r_j == r_n - IW'(1));
    assign w_emit_prev = r_hp && (r_ppos < PW'(ghls_pkg::MAX_RESULTS - 1));

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_fr    = r_fr;
        n_j     = r_j;
        n_pj    = r_pj;
        n_pos   = r_pos;
        n_ppos  = r_ppos;
        n_hp    = r_hp;
        n_fin   = r_fin;
        n_px    = r_px;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_of    = r_of;
        n_ol    = r_ol;
        case (r_state)
            ghls_pkg::P_IDLE: begin
                if (i_done.valid) begin
                    n_n  = i_done.count;
                    n_fr = i_done.first_row;
                    if (i_done.count < IW'(ghls_pkg::MIN_CENTERS)) begin
                        n_ox    = '0;
                        n_oy    = '0;
                        n_of    = 1'b0;
                        n_ol    = 1'b1;
                        n_state = ghls_pkg::P_OUT;
                    end else begin
                        n_j     = '0;
                        n_pos   = '0;
                        n_hp    = 1'b0;
                        n_fin   = 1'b0;
                        n_state = ghls_pkg::P_RD;
                    end
                end
            end
            ghls_pkg::P_RD: begin
                n_state = ghls_pkg::P_DATA;
            end
            ghls_pkg::P_DATA: begin
                n_px   = r_rq;
                n_pj   = r_j;
                n_ppos = r_pos;
                n_hp   = 1'b1;
                n_fin  = w_cur_last;
                n_j    = f_next(r_j, r_n);
                if (r_pos != PW'(ghls_pkg::MAX_RESULTS - 1)) begin
                    n_pos = r_pos + PW'(1);
                end
                if (w_emit_prev) begin
                    n_ox    = (r_rq == r_px) ? (r_px + ghls_pkg::X_W'(1)) : r_px;
                    n_oy    = f_y(r_fr, r_pj);
                    n_of    = 1'b1;
                    n_ol    = 1'b0;
                    n_state = ghls_pkg::P_OUT;
                end else if (w_cur_last) begin
                    n_ox    = r_rq;
                    n_oy    = f_y(r_fr, r_j);
                    n_of    = 1'b1;
                    n_ol    = 1'b1;
                    n_state = ghls_pkg::P_OUT;
                end else begin
                    n_state = ghls_pkg::P_RD;
                end
            end
            ghls_pkg::P_OUT: begin
                if (i_ready) begin
                    if (r_ol) begin
                        n_state = ghls_pkg::P_IDLE;
                    end else if (r_fin) begin
                        n_ox = r_px;
                        n_oy = f_y(r_fr, r_pj);
                        n_of = 1'b1;
                        n_ol = 1'b1;
                    end else begin
                        n_state = ghls_pkg::P_RD;
                    end
                end
            end
            default: begin
                n_state = ghls_pkg::P_IDLE;
            end
        endcase
    end

    assign o_idle   = (r_state == ghls_pkg::P_IDLE);
    assign o_valid  = (r_state == ghls_pkg::P_OUT);
    assign o_path_x = r_ox;
    assign o_path_y = r_oy;
    assign o_found  = r_of;
    assign o_last   = r_ol;

endmodule

// ----- rtl/core/grid_histogram_lane_search_top.sv -----
// Top level of the grid histogram lane search: handshakes, configuration register, assertions.
// Depends on ghls_pkg, ghls_search and ghls_path.
//
// Items are taken one at a time. For an add word the cell index is
// found by a reciprocal multiply, then the count memory is read and written back.
// A finish word reads the count memory one cell per cycle: a full row of GRID_COLS
// cells until a non-empty row is found, then at most 2*search_half_width cells per
// row; then a clearing pass writes all GRID_COLS*GRID_ROWS cells of the memory back
// to zero, and each result word waits for the output ready. After reset the block
// clears all GRID_COLS*GRID_ROWS cells of the count memory (512 by default) before
// it accepts a word; the configuration register may be written at any time the block
// is idle.
module grid_histogram_lane_search_top #(
    parameter int IMAGE_WIDTH  = ghls_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = ghls_pkg::IMAGE_HEIGHT_DEF,
    parameter int GRID_COLS    = ghls_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS    = ghls_pkg::GRID_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ghls_pkg::HW_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_cmd,
    input  logic [ghls_pkg::X_W-1:0]    i_point_x,
    input  logic [ghls_pkg::Y_W-1:0]    i_point_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ghls_pkg::X_W-1:0]    o_path_x,
    output logic [ghls_pkg::Y_W-1:0]    o_path_y,
    output logic                        o_found,
    output logic                        o_last
);

    logic [ghls_pkg::HW_W-1:0] r_hw;
    logic                      w_srch_idle;
    logic                      w_path_idle;
    ghls_pkg::t_ctr_wr         w_ctr_wr;
    ghls_pkg::t_run_done       w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw <= ghls_pkg::HW_W'(ghls_pkg::HW_RESET);
        end else if (i_cfg_we) begin
            r_hw <= i_cfg_wdata;
        end
    end

    assign o_ready = w_srch_idle && w_path_idle;

    ghls_search #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .GRID_COLS    (GRID_COLS),
        .GRID_ROWS    (GRID_ROWS)
    ) u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_valid && o_ready),
        .i_cmd    (i_cmd),
        .i_x      (i_point_x),
        .i_y      (i_point_y),
        .i_hw     (r_hw),
        .o_idle   (w_srch_idle),
        .o_ctr_wr (w_ctr_wr),
        .o_done   (w_done)
    );

    ghls_path #(
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .GRID_ROWS    (GRID_ROWS)
    ) u_path (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctr_wr (w_ctr_wr),
        .i_done   (w_done),
        .i_ready  (i_ready),
        .o_idle   (w_path_idle),
        .o_valid  (o_valid),
        .o_path_x (o_path_x),
        .o_path_y (o_path_y),
        .o_found  (o_found),
        .o_last   (o_last)
    );

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input word accepted while a result word is pending");

    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_cmd == ghls_pkg::CMD_FINISH)) |=> !o_ready)
        else $error("block ready right after a finish word");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_last && (o_path_x == '0) && (o_path_y == '0)))
        else $error("not-found result word is malformed");

    a_done_path_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done.valid |-> w_path_idle)
        else $error("search finished while the path sequencer was busy");

endmodule
